### rtl/ascp_pkg.sv
// ----------------------------------------------------------------------------
// ascp_pkg
// Shared types, constants and helper functions for the SGR color parser:
// parse modes, the control word of the sequencer, step addresses, the decode
// table that picks a routine, and the attribute update for one SGR code.
// ----------------------------------------------------------------------------
package ascp_pkg;

    // Longest held escape sequence
    localparam int MAX_SEQ = 16;
    localparam int IDX_W   = $clog2(MAX_SEQ);
    localparam int CNT_W   = $clog2(MAX_SEQ + 1);

    localparam logic [15:0] DEFAULT_ATTR_RST = 16'h0007;

    // Characters
    localparam logic [7:0] CH_ESC  = 8'd27;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;

    // SGR code ranges
    localparam logic [7:0] CODE_RESET  = 8'd0;
    localparam logic [7:0] CODE_FG_LO  = 8'd30;
    localparam logic [7:0] CODE_FG_HI  = 8'd37;
    localparam logic [7:0] CODE_FGB_LO = 8'd90;
    localparam logic [7:0] CODE_FGB_HI = 8'd97;
    localparam logic [7:0] CODE_BG_LO  = 8'd40;
    localparam logic [7:0] CODE_BG_HI  = 8'd47;
    localparam logic [7:0] CODE_BGB_LO = 8'd100;
    localparam logic [7:0] CODE_BGB_HI = 8'd107;

    localparam logic [11:0] FIELD_SAT = 12'd255;

    typedef enum logic [2:0] {
        MODE_TEXT  = 3'b001,
        MODE_ESC   = 3'b010,
        MODE_PARAM = 3'b100
    } t_mode;

    // Step addresses of the control program
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step S_IDLE      = 4'd0;
    localparam t_step S_DECODE    = 4'd1;
    localparam t_step S_TEXT      = 4'd2;
    localparam t_step S_ESC       = 4'd3;
    localparam t_step S_LBR       = 4'd4;
    localparam t_step S_DIGIT     = 4'd5;
    localparam t_step S_SEMI      = 4'd6;
    localparam t_step S_MAPPLY    = 4'd7;
    localparam t_step S_MCOMMIT   = 4'd8;
    localparam t_step S_BFL_START = 4'd9;
    localparam t_step S_BFL_EMIT  = 4'd10;
    localparam t_step S_BRK_IN    = 4'd11;
    localparam t_step S_CHK       = 4'd12;
    localparam t_step S_LFL_START = 4'd13;
    localparam t_step S_LFL_EMIT  = 4'd14;
    localparam t_step S_LFL_CLR   = 4'd15;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_DISPATCH,
        C_FLUSH_DONE,
        C_LAST_PENDING
    } t_cond;

    typedef enum logic [1:0] {
        E_NONE,
        E_INPUT,
        E_HELD,
        E_COMMIT
    } t_emit;

    typedef enum logic [1:0] {
        L_ZERO,
        L_ONE,
        L_FINAL
    } t_lastsel;

    typedef enum logic [1:0] {
        SM_KEEP,
        SM_ESC,
        SM_PARAM
    } t_setmode;

    typedef struct packed {
        t_cond    cond;
        t_step    target;
        t_step    alt;
        t_emit    emit;
        t_lastsel lsel;
        logic     capture;
        logic     hold;
        logic     hold_rst;
        t_setmode setmode;
        logic     clr;
        logic     load_working;
        logic     acc_digit;
        logic     apply;
        logic     field_clr;
        logic     commit;
        logic     idx_clr;
        logic     idx_inc;
    } t_ucode;

    // Color index to console bits: blue 1, green 2, red 4
    function automatic logic [2:0] colour_bits(input logic [2:0] idx);
        logic [2:0] c;
        unique case (idx)
            3'd0:    c = 3'd0;
            3'd1:    c = 3'd4;
            3'd2:    c = 3'd2;
            3'd3:    c = 3'd6;
            3'd4:    c = 3'd1;
            3'd5:    c = 3'd5;
            3'd6:    c = 3'd3;
            default: c = 3'd7;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] apply_code(input logic [7:0]  code,
                                               input logic [15:0] cur,
                                               input logic [15:0] dflt);
        logic [15:0] a;
        logic [7:0]  off_fg;
        logic [7:0]  off_fgb;
        logic [7:0]  off_bg;
        logic [7:0]  off_bgb;
        off_fg  = code - CODE_FG_LO;
        off_fgb = code - CODE_FGB_LO;
        off_bg  = code - CODE_BG_LO;
        off_bgb = code - CODE_BGB_LO;
        priority if (code == CODE_RESET) begin
            a = dflt;
        end else if (code >= CODE_FG_LO && code <= CODE_FG_HI) begin
            a = {cur[15:4], 1'b0, colour_bits(off_fg[2:0])};
        end else if (code >= CODE_FGB_LO && code <= CODE_FGB_HI) begin
            a = {cur[15:4], 1'b1, colour_bits(off_fgb[2:0])};
        end else if (code >= CODE_BG_LO && code <= CODE_BG_HI) begin
            a = {cur[15:8], 1'b0, colour_bits(off_bg[2:0]), cur[3:0]};
        end else if (code >= CODE_BGB_LO && code <= CODE_BGB_HI) begin
            a = {cur[15:8], 1'b1, colour_bits(off_bgb[2:0]), cur[3:0]};
        end else begin
            a = cur;
        end
        return a;
    endfunction

    // field * 10 + digit, saturating at 255
    function automatic logic [7:0] digit_acc(input logic [7:0] field,
                                             input logic [7:0] b);
        logic [11:0] v;
        v = {1'b0, field, 3'b000} + {3'b000, field, 1'b0} + {8'h00, b[3:0]};
        return (v > FIELD_SAT) ? 8'hFF : v[7:0];
    endfunction

    // Routine entry for the captured byte
    function automatic t_step dispatch(input t_mode      mode,
                                       input logic [7:0] b,
                                       input logic       full);
        logic  is_digit;
        t_step s;
        is_digit = (b >= CH_0) && (b <= CH_9);
        unique case (mode)
            MODE_ESC: begin
                s = (b == CH_LBR && !full) ? S_LBR : S_BFL_START;
            end
            MODE_PARAM: begin
                priority if (b == CH_M) begin
                    s = S_MAPPLY;
                end else if (is_digit && !full) begin
                    s = S_DIGIT;
                end else if (b == CH_SEMI && !full) begin
                    s = S_SEMI;
                end else begin
                    s = S_BFL_START;
                end
            end
            default: begin
                s = (b == CH_ESC) ? S_ESC : S_TEXT;
            end
        endcase
        return s;
    endfunction

endpackage

### rtl/ansi_sgr_color_parser_unit.sv
// An accepted byte is decoded in S_DECODE and handed to its routine: S_TEXT emits a
// text item, S_MAPPLY then S_MCOMMIT emit a commit, a broken sequence emits the held
// bytes and then the input byte, and a last byte that leaves a sequence pending
// flushes the held bytes. A new byte is accepted only when the sequencer is in S_IDLE.
// Each emit step stalls while the output register holds an item and i_out_ready is low.
// Reset (synchronous, i_rst_n low): text mode, nothing held, default and both attributes
// set to 0x0007, output register empty.
// ----------------------------------------------------------------------------
// ansi_sgr_color_parser_unit
// Byte stream SGR color parser driven by a microcoded sequencer: plain bytes
// pass tagged with the committed attribute, ESC [ ... m updates it, broken or
// unfinished sequences are flushed back out as text.
// ----------------------------------------------------------------------------
module ansi_sgr_color_parser_unit
    import ascp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_attr,
    output logic        o_out_last,
    input  logic        i_default_attr_we,
    input  logic [15:0] i_default_attr
);

    t_ucode uc;

    t_step             r_pc,        n_pc;
    t_mode             r_mode,      n_mode;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic [7:0]        r_field,     n_field;
    logic [15:0]       r_working,   n_working;
    logic [15:0]       r_committed, n_committed;
    logic [15:0]       r_dflt;
    logic [CNT_W-1:0]  r_rd_idx,    n_rd_idx;
    logic [7:0]        r_rd_data;
    logic [7:0]        r_byte;
    logic              r_last;
    logic [7:0]        r_held [MAX_SEQ];

    logic              r_out_valid;
    logic              r_out_kind;
    logic [7:0]        r_out_byte;
    logic [15:0]       r_out_attr;
    logic              r_out_last;

    logic              accept;
    logic              slot_free;
    logic              advance;
    logic              flush_final;
    logic              full;
    logic              cond_true;
    logic              emit_fire;
    logic              emit_kind;
    logic [7:0]        emit_byte;
    logic [15:0]       emit_attr;
    logic              emit_last;
    logic              hold_we;
    logic [IDX_W-1:0]  hold_addr;

    ascp_ucode_rom u_rom (
        .i_step  (r_pc),
        .o_ucode (uc)
    );

    assign o_in_ready  = (r_pc == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign advance     = (uc.emit == E_NONE) || slot_free;
    assign emit_fire   = (uc.emit != E_NONE) && slot_free;
    assign flush_final = ((r_rd_idx + CNT_W'(1)) == r_count);
    assign full        = (r_count >= CNT_W'(MAX_SEQ));
    assign hold_we     = uc.hold && advance;
    assign hold_addr   = uc.hold_rst ? '0 : r_count[IDX_W-1:0];

    always_comb begin
        unique case (uc.cond)
            C_ACCEPT:       cond_true = i_in_valid;
            C_FLUSH_DONE:   cond_true = flush_final;
            C_LAST_PENDING: cond_true = r_last && (r_mode != MODE_TEXT);
            default:        cond_true = 1'b1;
        endcase
    end

    always_comb begin
        unique case (uc.emit)
            E_HELD: begin
                emit_kind = 1'b0;
                emit_byte = r_rd_data;
                emit_attr = r_committed;
            end
            E_COMMIT: begin
                emit_kind = 1'b1;
                emit_byte = 8'h00;
                emit_attr = r_working;
            end
            default: begin
                emit_kind = 1'b0;
                emit_byte = r_byte;
                emit_attr = r_committed;
            end
        endcase
        unique case (uc.lsel)
            L_ONE:   emit_last = 1'b1;
            L_FINAL: emit_last = flush_final;
            default: emit_last = 1'b0;
        endcase
    end

    always_comb begin
        n_pc        = r_pc;
        n_mode      = r_mode;
        n_count     = r_count;
        n_field     = r_field;
        n_working   = r_working;
        n_committed = r_committed;
        n_rd_idx    = r_rd_idx;
        if (advance) begin
            if (uc.cond == C_DISPATCH) begin
                n_pc = dispatch(r_mode, r_byte, full);
            end else begin
                n_pc = cond_true ? uc.target : uc.alt;
            end
            if (uc.hold) begin
                n_count = uc.hold_rst ? CNT_W'(1) : r_count + CNT_W'(1);
            end
            unique case (uc.setmode)
                SM_ESC:   n_mode = MODE_ESC;
                SM_PARAM: n_mode = MODE_PARAM;
                default:  n_mode = r_mode;
            endcase
            if (uc.load_working) begin
                n_working = r_committed;
            end
            if (uc.apply) begin
                n_working = apply_code(r_field, r_working, r_dflt);
            end
            if (uc.acc_digit) begin
                n_field = digit_acc(r_field, r_byte);
            end
            if (uc.field_clr) begin
                n_field = 8'h00;
            end
            if (uc.commit) begin
                n_committed = r_working;
            end
            if (uc.clr) begin
                n_count = '0;
                n_mode  = MODE_TEXT;
                n_field = 8'h00;
            end
            if (uc.idx_clr) begin
                n_rd_idx = '0;
            end
            if (uc.idx_inc) begin
                n_rd_idx = r_rd_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= S_IDLE;
            r_mode      <= MODE_TEXT;
            r_count     <= '0;
            r_field     <= 8'h00;
            r_working   <= DEFAULT_ATTR_RST;
            r_committed <= DEFAULT_ATTR_RST;
            r_dflt      <= DEFAULT_ATTR_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_field     <= n_field;
            r_working   <= n_working;
            r_committed <= n_committed;
            if (i_default_attr_we) begin
                r_dflt <= i_default_attr;
            end
            if (slot_free) begin
                r_out_valid <= emit_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        if (accept && uc.capture) begin
            r_byte <= i_in_byte;
            r_last <= i_in_last;
        end
        if (emit_fire) begin
            r_out_kind <= emit_kind;
            r_out_byte <= emit_byte;
            r_out_attr <= emit_attr;
            r_out_last <= emit_last;
        end
    end

    // held sequence store
    always_ff @(posedge i_clk) begin
        if (hold_we) begin
            r_held[hold_addr] <= r_byte;
        end
        r_rd_data <= r_held[n_rd_idx[IDX_W-1:0]];
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_out_byte  = r_out_byte;
    assign o_attr      = r_out_attr;
    assign o_out_last  = r_out_last;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SEQ))
        else $error("held count beyond limit");

    a_pending_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_TEXT) |-> (r_count != '0))
        else $error("sequence pending with nothing held");

    a_esc_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ESC) |-> (r_count == CNT_W'(1)))
        else $error("after ESC exactly one byte must be held");

    a_commit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind) |-> (r_out_byte == 8'h00))
        else $error("commit item carries a byte");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_pc == S_DECODE))
        else $error("accepted item not decoded next");
`endif

endmodule

### rtl/ascp_ucode_rom.sv
// ----------------------------------------------------------------------------
// ascp_ucode_rom
// Control store of the parser sequencer: one control word per step.
// ----------------------------------------------------------------------------
module ascp_ucode_rom
    import ascp_pkg::*;
(
    input  t_step  i_step,
    output t_ucode o_ucode
);

    always_comb begin
        o_ucode        = '0;
        o_ucode.cond   = C_ALWAYS;
        o_ucode.target = S_IDLE;
        o_ucode.alt    = S_IDLE;
        unique case (i_step)
            S_IDLE: begin
                o_ucode.cond    = C_ACCEPT;
                o_ucode.target  = S_DECODE;
                o_ucode.alt     = S_IDLE;
                o_ucode.capture = 1'b1;
            end
            S_DECODE: begin
                o_ucode.cond = C_DISPATCH;
            end
            S_TEXT: begin
                o_ucode.emit = E_INPUT;
                o_ucode.lsel = L_ONE;
            end
            S_ESC: begin
                o_ucode.hold     = 1'b1;
                o_ucode.hold_rst = 1'b1;
                o_ucode.setmode  = SM_ESC;
                o_ucode.target   = S_CHK;
            end
            S_LBR: begin
                o_ucode.hold         = 1'b1;
                o_ucode.setmode      = SM_PARAM;
                o_ucode.field_clr    = 1'b1;
                o_ucode.load_working = 1'b1;
                o_ucode.target       = S_CHK;
            end
            S_DIGIT: begin
                o_ucode.hold      = 1'b1;
                o_ucode.acc_digit = 1'b1;
                o_ucode.target    = S_CHK;
            end
            S_SEMI: begin
                o_ucode.hold      = 1'b1;
                o_ucode.apply     = 1'b1;
                o_ucode.field_clr = 1'b1;
                o_ucode.target    = S_CHK;
            end
            S_MAPPLY: begin
                o_ucode.apply  = 1'b1;
                o_ucode.target = S_MCOMMIT;
            end
            S_MCOMMIT: begin
                o_ucode.emit   = E_COMMIT;
                o_ucode.lsel   = L_ONE;
                o_ucode.commit = 1'b1;
                o_ucode.clr    = 1'b1;
            end
            S_BFL_START: begin
                o_ucode.idx_clr = 1'b1;
                o_ucode.target  = S_BFL_EMIT;
            end
            S_BFL_EMIT: begin
                o_ucode.emit    = E_HELD;
                o_ucode.lsel    = L_ZERO;
                o_ucode.idx_inc = 1'b1;
                o_ucode.cond    = C_FLUSH_DONE;
                o_ucode.target  = S_BRK_IN;
                o_ucode.alt     = S_BFL_EMIT;
            end
            S_BRK_IN: begin
                o_ucode.emit = E_INPUT;
                o_ucode.lsel = L_ONE;
                o_ucode.clr  = 1'b1;
            end
            S_CHK: begin
                o_ucode.cond   = C_LAST_PENDING;
                o_ucode.target = S_LFL_START;
                o_ucode.alt    = S_IDLE;
            end
            S_LFL_START: begin
                o_ucode.idx_clr = 1'b1;
                o_ucode.target  = S_LFL_EMIT;
            end
            S_LFL_EMIT: begin
                o_ucode.emit    = E_HELD;
                o_ucode.lsel    = L_FINAL;
                o_ucode.idx_inc = 1'b1;
                o_ucode.cond    = C_FLUSH_DONE;
                o_ucode.target  = S_LFL_CLR;
                o_ucode.alt     = S_LFL_EMIT;
            end
            S_LFL_CLR: begin
                o_ucode.clr = 1'b1;
            end
            default: begin
                o_ucode.target = S_IDLE;
            end
        endcase
    end

endmodule
